@@ src/mm_pkg.sv @@
package mm_pkg;

  // matrix geometry
  localparam int unsigned MAX_DIM    = 8;
  localparam int unsigned DIM_W      = $clog2(MAX_DIM);
  localparam int unsigned DEPTH      = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W     = 2 * DIM_W;

  // arithmetic widths
  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned PROD_W     = 2 * ELEM_W;
  localparam int unsigned ACC_W      = 40;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

  // controller states
  typedef enum logic {
    ST_LOAD,
    ST_CALC
  } state_e;

  // tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic             first;
    logic             last;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             last_run;
  } mm_tag_t;

  // command from controller to datapath
  typedef struct packed {
    logic              wr_en;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    mm_tag_t           tag;
  } mm_cmd_t;

  // register value to highest index: zero acts as one, above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_DATA_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > CFG_DATA_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = DIM_W'(v - 1'b1);
    end
    return r;
  endfunction

endpackage

@@ src/matrix_multiply.sv @@
// Dense matrix multiply C = A x B in fixed point (Q3.12 in, Q15.24 out).
// Dimensions l (rows_a), m (inner_dim) and n (cols_b) come from the write
// port: cfg_we_i with cfg_idx_i 0, 1 or 2 and a 4-bit value; zero acts as one,
// values above 8 act as 8. Any write to a valid index restarts the load.
// Elements arrive on element_value_i, taken when start_i is high and busy_o
// is low: all of A row-major, then all of B row-major, one item a cycle.
// The last element of B starts the compute phase; busy_o stays high while a
// single multiply-accumulate unit walks the stores, one product per cycle,
// since both stores have one read port each.
// Results of C leave in row-major order on result_valid_o, one cycle each,
// with out_row_o and out_col_o, and last_of_run_o marks the final element.
// Each step passes the store read, product and output registers in turn.
// A whole run loads (l+n)*m elements and makes l*n*m multiply-accumulate
// steps; at 8x8x8 that is 128 elements.
// Results cannot be held off: each strobe lasts one cycle.
// Reset returns all dimensions to 8 and the load to element A[0][0]; store
// contents are not cleared.
module matrix_multiply
  import mm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [ELEM_W-1:0] element_value_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  output logic                     result_valid_o,
  output logic signed [ACC_W-1:0]  product_value_o,
  output logic [DIM_W-1:0]         out_row_o,
  output logic [DIM_W-1:0]         out_col_o,
  output logic                     last_of_run_o
);

  mm_cmd_t cmd;

  // sequencing of loads and multiply-accumulate steps
  mm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (cmd)
  );

  // stores, multiplier and accumulator
  mm_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .element_value_i (element_value_i),
    .result_valid_o  (result_valid_o),
    .product_value_o (product_value_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

@@ src/mm_ctrl.sv @@
module mm_ctrl
  import mm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output mm_cmd_t               cmd_o
);

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic                  cfg_hit;

  logic             ld_b_q, ld_b_d;
  logic [DIM_W-1:0] ld_row_q, ld_row_d;
  logic [DIM_W-1:0] ld_col_q, ld_col_d;
  logic [DIM_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

  logic [DIM_W-1:0] l_last, m_last, n_last;
  logic [DIM_W-1:0] ld_row_last, ld_col_last;
  logic             accept;
  logic             i_end, j_end, k_end;

  // configuration registers
  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_ROWS_A || cfg_idx_i == REG_INNER_DIM ||
                                cfg_idx_i == REG_COLS_B);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROWS_A:    rows_a_q    <= cfg_data_i;
        REG_INNER_DIM: inner_dim_q <= cfg_data_i;
        REG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign l_last = dim_last(rows_a_q);
  assign m_last = dim_last(inner_dim_q);
  assign n_last = dim_last(cols_b_q);

  // load geometry: A is l by m, B is m by n
  assign ld_row_last = ld_b_q ? m_last : l_last;
  assign ld_col_last = ld_b_q ? n_last : m_last;

  assign busy_o = (state_q == ST_CALC);
  assign accept = start_i && !busy_o;

  assign i_end = (i_q == l_last);
  assign j_end = (j_q == n_last);
  assign k_end = (k_q == m_last);

  // state register and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      ld_b_q   <= 1'b0;
      ld_row_q <= '0;
      ld_col_q <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      ld_b_q   <= ld_b_d;
      ld_row_q <= ld_row_d;
      ld_col_q <= ld_col_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d  = state_q;
    ld_b_d   = ld_b_q;
    ld_row_d = ld_row_q;
    ld_col_d = ld_col_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;

    cmd_o.wr_en        = 1'b0;
    cmd_o.wr_b         = ld_b_q;
    cmd_o.wr_addr      = {ld_row_q, ld_col_q};
    cmd_o.rd_en        = 1'b0;
    cmd_o.rd_a_addr    = {i_q, k_q};
    cmd_o.rd_b_addr    = {k_q, j_q};
    cmd_o.tag.first    = (k_q == '0);
    cmd_o.tag.last     = k_end;
    cmd_o.tag.row      = i_q;
    cmd_o.tag.col      = j_q;
    cmd_o.tag.last_run = i_end && j_end && k_end;

    case (state_q)
      ST_LOAD: begin
        if (cfg_hit) begin
          // a register write restarts the load
          ld_b_d   = 1'b0;
          ld_row_d = '0;
          ld_col_d = '0;
        end else if (accept) begin
          cmd_o.wr_en = 1'b1;
          if (ld_col_q == ld_col_last) begin
            ld_col_d = '0;
            if (ld_row_q == ld_row_last) begin
              ld_row_d = '0;
              if (ld_b_q) begin
                ld_b_d  = 1'b0;
                i_d     = '0;
                j_d     = '0;
                k_d     = '0;
                state_d = ST_CALC;
              end else begin
                ld_b_d = 1'b1;
              end
            end else begin
              ld_row_d = ld_row_q + 1'b1;
            end
          end else begin
            ld_col_d = ld_col_q + 1'b1;
          end
        end
      end
      ST_CALC: begin
        cmd_o.rd_en = 1'b1;
        if (k_end) begin
          k_d = '0;
          if (j_end) begin
            j_d = '0;
            if (i_end) begin
              i_d     = '0;
              state_d = ST_LOAD;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

@@ src/mm_datapath.sv @@
module mm_datapath
  import mm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mm_cmd_t                  cmd_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  output logic                     result_valid_o,
  output logic signed [ACC_W-1:0]  product_value_o,
  output logic [DIM_W-1:0]         out_row_o,
  output logic [DIM_W-1:0]         out_col_o,
  output logic                     last_of_run_o
);

  logic [ELEM_W-1:0] a_mem [DEPTH];
  logic [ELEM_W-1:0] b_mem [DEPTH];

  logic                     s1_valid_q, s2_valid_q;
  mm_tag_t                  s1_tag_q, s2_tag_q;
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     out_valid_q;
  logic signed [ACC_W-1:0]  out_value_q;
  logic [DIM_W-1:0]         out_row_q, out_col_q;
  logic                     out_last_q;

  // operand stores, one write and one read port each
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !cmd_i.wr_b) begin
      a_mem[cmd_i.wr_addr] <= element_value_i;
    end
    a_rd_q <= a_mem[cmd_i.rd_a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.wr_b) begin
      b_mem[cmd_i.wr_addr] <= element_value_i;
    end
    b_rd_q <= b_mem[cmd_i.rd_b_addr];
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= cmd_i.rd_en;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q && s2_tag_q.last;
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    s1_tag_q <= cmd_i.tag;
    s2_tag_q <= s1_tag_q;
    prod_q   <= a_rd_q * b_rd_q;
  end

  // accumulate, restarting on the first term of each dot product
  always_comb begin
    if (s2_tag_q.first) begin
      acc_d = ACC_W'(prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
    if (s2_valid_q && s2_tag_q.last) begin
      out_value_q <= acc_d;
      out_row_q   <= s2_tag_q.row;
      out_col_q   <= s2_tag_q.col;
      out_last_q  <= s2_tag_q.last_run;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign product_value_o = out_value_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign last_of_run_o   = out_last_q;

endmodule
